@@ sv/ihash_pkg.sv @@
package ihash_pkg;

    localparam int ID_BITS               = 32;
    localparam int HANDLE_PORT_BITS      = 16;
    localparam int DEF_BUCKET_INDEX_BITS = 8;
    localparam int DEF_BUCKET_WAYS       = 4;
    localparam int DEF_HANDLE_BITS       = 16;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FIND    = 2'd2,
        OP_PEEK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // outcome of evaluating one bucket row
    typedef struct packed {
        logic                        wr_en;
        status_t                     status;
        logic [HANDLE_PORT_BITS-1:0] handle;
    } lookup_res_t;

endpackage

@@ sv/ihash_ram.sv @@
module ihash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/ihash_match.sv @@
module ihash_match import ihash_pkg::*; #(
    parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    localparam int ENTRY_BITS = 1 + ID_BITS + HANDLE_BITS,
    localparam int ROW_BITS   = BUCKET_WAYS * ENTRY_BITS
) (
    input  op_t                    op,
    input  logic [ID_BITS-1:0]     req_id,
    input  logic [ID_BITS-1:0]     alloc_id,
    input  logic [HANDLE_BITS-1:0] req_handle,
    input  logic [ROW_BITS-1:0]    row,
    output logic [ROW_BITS-1:0]    new_row,
    output lookup_res_t            res
);

    // entry layout: {valid, id, handle}
    logic [BUCKET_WAYS-1:0]                  way_hit;
    logic                                    found;
    logic [HANDLE_BITS-1:0]                  hit_handle;
    logic [HANDLE_BITS+HANDLE_PORT_BITS-1:0] handle_ext;

    always_comb begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            logic                   v;
            logic [ID_BITS-1:0]     eid;
            logic [HANDLE_BITS-1:0] eh;
            v   = row[w*ENTRY_BITS + ENTRY_BITS - 1];
            eid = row[w*ENTRY_BITS + HANDLE_BITS +: ID_BITS];
            eh  = row[w*ENTRY_BITS +: HANDLE_BITS];
            unique case (op)
                OP_ALLOC:   way_hit[w] = !v;
                OP_RELEASE: way_hit[w] = v && (eh == req_handle);
                OP_FIND:    way_hit[w] = v && (eid == req_id);
                default:    way_hit[w] = 1'b0;
            endcase
        end
    end

    // lowest-numbered hit wins
    always_comb begin
        found      = 1'b0;
        hit_handle = '0;
        new_row    = row;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!found && way_hit[w]) begin
                found      = 1'b1;
                hit_handle = row[w*ENTRY_BITS +: HANDLE_BITS];
                if (op == OP_ALLOC) begin
                    new_row[w*ENTRY_BITS +: ENTRY_BITS] = {1'b1, alloc_id, req_handle};
                end else begin
                    new_row[w*ENTRY_BITS + ENTRY_BITS - 1] = 1'b0;
                end
            end
        end
    end

    assign handle_ext = {{HANDLE_PORT_BITS{1'b0}}, hit_handle};

    always_comb begin
        res.wr_en  = 1'b0;
        res.handle = '0;
        res.status = ST_OK;
        unique case (op)
            OP_ALLOC: begin
                res.wr_en  = found;
                res.status = found ? ST_OK : ST_FULL;
            end
            OP_RELEASE: begin
                res.wr_en  = found;
                res.status = found ? ST_OK : ST_MISS;
            end
            OP_FIND: begin
                res.handle = found ? handle_ext[HANDLE_PORT_BITS-1:0] : '0;
                res.status = found ? ST_OK : ST_MISS;
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
    end

endmodule

@@ sv/id_allocating_hash_table_top.sv @@
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  s_op, s_id_in, s_handle_in
// m_        out        m_valid / m_ready  m_id_out, m_handle_out, m_status
// cfg_      in         cfg_wr_en          cfg_wr_data (first_id, no read-back)
//
// For each request the accept cycle issues the bucket read, and the lookup
// state evaluates the registered row from the RAM, writes it back and loads
// the output register.
// After reset a clearing pass writes all 2**BUCKET_INDEX_BITS bucket rows
// (256 by default) to empty, one row per cycle, with s_ready low.
// A held result in the output register stalls the lookup cycle; the next
// word is taken once the lookup has retired.
module id_allocating_hash_table_top import ihash_pkg::*; #(
    parameter int BUCKET_INDEX_BITS = DEF_BUCKET_INDEX_BITS,
    parameter int BUCKET_WAYS       = DEF_BUCKET_WAYS,
    parameter int HANDLE_BITS       = DEF_HANDLE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [ID_BITS-1:0]          s_id_in,
    input  logic [HANDLE_PORT_BITS-1:0] s_handle_in,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ID_BITS-1:0]          m_id_out,
    output logic [HANDLE_PORT_BITS-1:0] m_handle_out,
    output logic [1:0]                  m_status,
    // first_id register
    input  logic                        cfg_wr_en,
    input  logic [ID_BITS-1:0]          cfg_wr_data
);

    localparam int NUM_BUCKETS = 1 << BUCKET_INDEX_BITS;
    localparam int ENTRY_BITS  = 1 + ID_BITS + HANDLE_BITS;
    localparam int ROW_BITS    = BUCKET_WAYS * ENTRY_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    state_t                        state_reg, state_next;
    logic [BUCKET_INDEX_BITS-1:0]  clr_idx_reg, clr_idx_next;
    logic [BUCKET_INDEX_BITS-1:0]  bucket_reg, bucket_next;
    op_t                           op_reg, op_next;
    logic [ID_BITS-1:0]            id_reg, id_next;
    logic [HANDLE_BITS-1:0]        handle_reg, handle_next;
    logic [ID_BITS-1:0]            counter_reg, counter_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0]            m_id_reg, m_id_next;
    logic [HANDLE_PORT_BITS-1:0]   m_handle_reg, m_handle_next;
    status_t                       m_status_reg, m_status_next;

    logic                          accept;
    logic                          out_free;
    op_t                           s_op_t;
    logic [HANDLE_BITS+HANDLE_PORT_BITS-1:0] handle_in_ext;
    logic [BUCKET_INDEX_BITS-1:0]  rd_bucket;

    logic                          ram_wr_en;
    logic [BUCKET_INDEX_BITS-1:0]  ram_wr_addr;
    logic [ROW_BITS-1:0]           ram_wr_data;
    logic [ROW_BITS-1:0]           ram_rd_data;
    logic [ROW_BITS-1:0]           new_row;
    lookup_res_t                   look_res;

    assign s_op_t        = op_t'(s_op);
    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    // handle kept in HANDLE_BITS: truncate or zero-extend the port value
    assign handle_in_ext = {{HANDLE_BITS{1'b0}}, s_handle_in};

    // Bucket read: fresh address while idle, otherwise hold the current
    // bucket so the registered row stays valid across output stalls.
    always_comb begin
        if (state_reg == S_IDLE) begin
            rd_bucket = (s_op_t == OP_ALLOC) ? counter_reg[BUCKET_INDEX_BITS-1:0]
                                             : s_id_in[BUCKET_INDEX_BITS-1:0];
        end else begin
            rd_bucket = bucket_reg;
        end
    end

    ihash_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_bucket),
        .rd_data (ram_rd_data)
    );

    ihash_match #(
        .BUCKET_WAYS (BUCKET_WAYS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_match (
        .op         (op_reg),
        .req_id     (id_reg),
        .alloc_id   (counter_reg),
        .req_handle (handle_reg),
        .row        (ram_rd_data),
        .new_row    (new_row),
        .res        (look_res)
    );

    // Write port: clearing pass after reset, else write-back of the row.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = bucket_reg;
        ram_wr_data = new_row;
        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_idx_reg;
                ram_wr_data = '0;
            end
            S_LOOK: begin
                ram_wr_en = out_free && look_res.wr_en;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        bucket_next   = bucket_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        handle_next   = handle_reg;
        counter_next  = counter_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_id_next     = m_id_reg;
        m_handle_next = m_handle_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            S_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == {BUCKET_INDEX_BITS{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    bucket_next = rd_bucket;
                    op_next     = s_op_t;
                    id_next     = s_id_in;
                    handle_next = handle_in_ext[HANDLE_BITS-1:0];
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_handle_next = look_res.handle;
                    m_status_next = look_res.status;
                    // alloc and peek report the counter, the rest echo the id
                    m_id_next     = (op_reg == OP_ALLOC || op_reg == OP_PEEK)
                                    ? counter_reg : id_reg;
                    if (op_reg == OP_ALLOC) begin
                        // consumed even when the bucket is full
                        counter_next = counter_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            counter_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
        bucket_reg   <= bucket_next;
        op_reg       <= op_next;
        id_reg       <= id_next;
        handle_reg   <= handle_next;
        m_id_reg     <= m_id_next;
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_id_out     = m_id_reg;
    assign m_handle_out = m_handle_reg;
    assign m_status     = m_status_reg;

    // no RAM write while waiting for a request
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !ram_wr_en)
        else $error("RAM write while idle");

    // a new result only comes out of a lookup cycle
    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_LOOK)
        else $error("result without lookup");

    // counter moves only on a config write or a retired allocate
    a_counter_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(counter_reg)) |->
            ($past(cfg_wr_en) ||
             ($past(state_reg) == S_LOOK && $past(op_reg) == OP_ALLOC && $past(out_free))))
        else $error("unexpected counter change");

    // lookup always lasts until the output register frees up
    a_look_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOK && !out_free) |=> state_reg == S_LOOK)
        else $error("lookup dropped while output stalled");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import ihash_pkg::*;;

    localparam int NUM_BUCKETS  = 1 << DEF_BUCKET_INDEX_BITS;
    localparam int NUM_WAYS     = DEF_BUCKET_WAYS;
    localparam int N_DIRECTED   = 28;
    localparam int N_PHASES     = 9;
    localparam int PHASE_WORDS  = 100;
    // clearing pass writes 256 rows; receiver stalls are geometric, so this is generous
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 4;

    // ---------------------------------------------------------------
    // Clock, reset and DUT ports
    // ---------------------------------------------------------------
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_op        = '0;
    logic [ID_BITS-1:0]          s_id_in     = '0;
    logic [HANDLE_PORT_BITS-1:0] s_handle_in = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [ID_BITS-1:0]          m_id_out;
    logic [HANDLE_PORT_BITS-1:0] m_handle_out;
    logic [1:0]                  m_status;
    logic                        cfg_wr_en   = 1'b0;
    logic [ID_BITS-1:0]          cfg_wr_data = '0;

    always #2 aclk = ~aclk;

    id_allocating_hash_table_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_id_in      (s_id_in),
        .s_handle_in  (s_handle_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_id_out     (m_id_out),
        .m_handle_out (m_handle_out),
        .m_status     (m_status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the table: allocation counter and buckets
    // ---------------------------------------------------------------
    typedef struct packed {
        logic                        valid;
        logic [ID_BITS-1:0]          id;
        logic [HANDLE_PORT_BITS-1:0] handle;
    } slot_t;

    typedef struct packed {
        logic [ID_BITS-1:0]          id;
        logic [HANDLE_PORT_BITS-1:0] handle;
        status_t                     status;
    } result_word_t;

    slot_t              shadow_buckets [NUM_BUCKETS][NUM_WAYS];
    logic [ID_BITS-1:0] shadow_next_id;

    result_word_t expected_words [$];
    int           mismatch_count = 0;
    int           tx_idle_pct    = 0;
    int           rx_idle_pct    = 0;
    int           stall_cycles   = 0;

    // Applies one request to the shadow table and returns the word it yields.
    // Release matches on handle only; find and allocate take the lowest way.
    function automatic result_word_t predict_table_op(
        input op_t                         op,
        input logic [ID_BITS-1:0]          id,
        input logic [HANDLE_PORT_BITS-1:0] handle
    );
        result_word_t r;
        int           b;
        r.id     = id;
        r.handle = '0;
        r.status = ST_MISS;
        case (op)
            OP_ALLOC: begin
                b = int'(shadow_next_id[DEF_BUCKET_INDEX_BITS-1:0]);
                r.id   = shadow_next_id;
                r.status = ST_FULL;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (!shadow_buckets[b][w].valid) begin
                        shadow_buckets[b][w] = '{1'b1, shadow_next_id, handle};
                        r.status = ST_OK;
                        break;
                    end
                end
                // counter moves on even when the bucket is full
                shadow_next_id = shadow_next_id + 1;
            end
            OP_RELEASE: begin
                b = int'(id[DEF_BUCKET_INDEX_BITS-1:0]);
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (shadow_buckets[b][w].valid && shadow_buckets[b][w].handle == handle) begin
                        shadow_buckets[b][w].valid = 1'b0;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            OP_FIND: begin
                b = int'(id[DEF_BUCKET_INDEX_BITS-1:0]);
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (shadow_buckets[b][w].valid && shadow_buckets[b][w].id == id) begin
                        r.handle = shadow_buckets[b][w].handle;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            default: begin
                r.id     = shadow_next_id;
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    // Picks a live entry from a random starting point; returns 0 if the table is empty.
    function automatic bit pick_live_entry(
        output logic [ID_BITS-1:0]          id,
        output logic [HANDLE_PORT_BITS-1:0] handle
    );
        int b0;
        int w0;
        int b;
        int w;
        b0 = $urandom_range(NUM_BUCKETS - 1);
        w0 = $urandom_range(NUM_WAYS - 1);
        id     = '0;
        handle = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            for (int j = 0; j < NUM_WAYS; j++) begin
                b = (b0 + i) % NUM_BUCKETS;
                w = (w0 + j) % NUM_WAYS;
                if (shadow_buckets[b][w].valid) begin
                    id     = shadow_buckets[b][w].id;
                    handle = shadow_buckets[b][w].handle;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // random gap before a word; s_valid is only dropped when a gap is taken
    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Presents one word and holds it until accepted. Called just after a rising edge.
    // Returns the word the shadow table predicts for it.
    task automatic send_request(
        input  op_t                         op,
        input  logic [ID_BITS-1:0]          id,
        input  logic [HANDLE_PORT_BITS-1:0] handle,
        output result_word_t                predicted
    );
        s_valid     <= 1'b1;
        s_op        <= op;
        s_id_in     <= id;
        s_handle_in <= handle;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_table_op(op, id, handle);
    endtask

    // Pause the sender until every outstanding word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // first_id write: also reloads the allocation counter
    task automatic load_first_id(input logic [ID_BITS-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        shadow_next_id  = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_request();
        op_t                         op;
        logic [ID_BITS-1:0]          id;
        logic [HANDLE_PORT_BITS-1:0] handle;
        result_word_t                predicted;
        int                          pick;
        pick   = $urandom_range(99);
        id     = $urandom;
        handle = HANDLE_PORT_BITS'($urandom_range(16'hFFFF));
        if (pick < 35) begin
            op = OP_ALLOC;
        end else if (pick < 60) begin
            op = OP_RELEASE;
            // mostly target something live; otherwise a likely miss
            if ($urandom_range(99) < 80) void'(pick_live_entry(id, handle));
        end else if (pick < 90) begin
            op = OP_FIND;
            if ($urandom_range(99) < 80) void'(pick_live_entry(id, handle));
        end else begin
            op = OP_PEEK;
        end
        sender_gap();
        send_request(op, id, handle, predicted);
        expected_words.push_back(predicted);
    endtask

    // ---------------------------------------------------------------
    // Directed table: fixed expectations only where obvious
    // ---------------------------------------------------------------
    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;
    typedef enum logic { EXP_MODEL, EXP_FIXED } exp_src_t;

    typedef struct packed {
        row_kind_t                   kind;
        op_t                         op;
        logic [ID_BITS-1:0]          id;      // first_id value on CFG rows
        logic [HANDLE_PORT_BITS-1:0] handle;
        exp_src_t                    src;
        logic [ID_BITS-1:0]          exp_id;
        logic [HANDLE_PORT_BITS-1:0] exp_handle;
        status_t                     exp_status;
    } stim_row_t;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // empty table after reset, counter at zero
        '{ROW_REQ, OP_PEEK,    32'h0000_0000, 16'h0000, EXP_FIXED, 32'h0000_0000, 16'h0000, ST_OK},
        '{ROW_REQ, OP_FIND,    32'h0000_0000, 16'hFFFF, EXP_FIXED, 32'h0000_0000, 16'h0000, ST_MISS},
        '{ROW_REQ, OP_RELEASE, 32'hFFFF_FFFF, 16'hFFFF, EXP_FIXED, 32'hFFFF_FFFF, 16'h0000, ST_MISS},
        '{ROW_REQ, OP_ALLOC,   32'hFFFF_FFFF, 16'hFFFF, EXP_FIXED, 32'h0000_0000, 16'h0000, ST_OK},
        '{ROW_REQ, OP_FIND,    32'h0000_0000, 16'h0000, EXP_FIXED, 32'h0000_0000, 16'hFFFF, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        // counter wrap, then a duplicate id 0 in bucket 0
        '{ROW_CFG, OP_PEEK,    32'hFFFF_FFFE, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_PEEK,    32'h0000_0000, 16'h0000, EXP_FIXED, 32'hFFFF_FFFE, 16'h0000, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h1234, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'hABCD, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h5555, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_FIND,    32'h0000_0000, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_PEEK,    32'h0000_0000, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        // reload to 0x100 three times: bucket 0 fills, the last alloc overflows
        '{ROW_CFG, OP_PEEK,    32'h0000_0100, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h0AAA, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_CFG, OP_PEEK,    32'h0000_0100, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h0AAA, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_CFG, OP_PEEK,    32'h0000_0100, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'h7777, EXP_FIXED, 32'h0000_0100, 16'h0000, ST_FULL},
        // release by handle only, from any id that maps to bucket 0
        '{ROW_REQ, OP_RELEASE, 32'h0000_0300, 16'h0AAA, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_FIND,    32'h0000_0100, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_RELEASE, 32'h0000_0000, 16'h0AAA, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_RELEASE, 32'h0000_0000, 16'h0AAA, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_CFG, OP_PEEK,    32'h0000_0000, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_PEEK,    32'h0000_0000, 16'h0000, EXP_FIXED, 32'h0000_0000, 16'h0000, ST_OK},
        '{ROW_REQ, OP_FIND,    32'h8000_0000, 16'h0000, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC,   32'h0000_0000, 16'hFFFF, EXP_MODEL, 32'h0, 16'h0, ST_OK},
        '{ROW_REQ, OP_RELEASE, 32'h0000_0000, 16'hFFFF, EXP_MODEL, 32'h0, 16'h0, ST_OK}
    };

    // first_id per random phase: repeated 0x1000 reloads make full buckets and
    // duplicate ids; the high values wrap; 0 means a fresh random value, but phase 3 keeps 0
    logic [ID_BITS-1:0] phase_first_id [N_PHASES] = '{
        32'h0000_1000, 32'hFFFF_FFC0, 32'h0000_1000,
        32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFFF,
        32'h0000_1000, 32'h0000_0000, 32'h0000_1000
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        result_word_t       predicted;
        logic [ID_BITS-1:0] cfg_value;

        shadow_next_id  = '0;
        for (int b = 0; b < NUM_BUCKETS; b++)
            for (int w = 0; w < NUM_WAYS; w++)
                shadow_buckets[b][w] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 83;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                load_first_id(directed_rows[i].id);
            end else begin
                sender_gap();
                send_request(directed_rows[i].op, directed_rows[i].id,
                             directed_rows[i].handle, predicted);
                if (directed_rows[i].src == EXP_FIXED)
                    predicted = '{directed_rows[i].exp_id, directed_rows[i].exp_handle,
                                  directed_rows[i].exp_status};
                expected_words.push_back(predicted);
            end
        end

        // random phases; idling mode switches every third phase
        for (int p = 0; p < N_PHASES; p++) begin
            cfg_value = phase_first_id[p];
            if (cfg_value == 32'h0000_0000 && p != 3) cfg_value = $urandom;
            load_first_id(cfg_value);
            case (p / 3)
                0:       begin tx_idle_pct = 20; rx_idle_pct = 83; end
                1:       begin tx_idle_pct = 83; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_request();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random backpressure and in-order check
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual id %h handle %h status %0d",
                         $time, m_id_out, m_handle_out, m_status);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_id_out !== want.id) begin
                    $display("%0t: id_out mismatch, expected %h, actual %h",
                             $time, want.id, m_id_out);
                    mismatch_count++;
                end
                if (m_handle_out !== want.handle) begin
                    $display("%0t: handle_out mismatch, expected %h, actual %h",
                             $time, want.handle, m_handle_out);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
